// ----- rtl/core/tsh_pkg.sv -----
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared types and constants for the two-axis stepper homing core.
// ----------------------------------------------------------------------------
`default_nettype none

package tsh_pkg;

  localparam int unsigned CFG_WIDTH     = 16;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_COARSE       = 3'd1,
    PH_BACKOFF      = 3'd2,
    PH_FINE         = 3'd3,
    PH_FINE_BACKOFF = 3'd4,
    PH_DONE         = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_COARSE_INTERVAL  = 2'd0,
    REG_FINE_INTERVAL    = 2'd1,
    REG_BACKOFF_INTERVAL = 2'd2,
    REG_BACKOFF_LENGTH   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  localparam logic [CFG_WIDTH-1:0] RST_COARSE_INTERVAL  = 16'd4;
  localparam logic [CFG_WIDTH-1:0] RST_FINE_INTERVAL    = 16'd16;
  localparam logic [CFG_WIDTH-1:0] RST_BACKOFF_INTERVAL = 16'd8;
  localparam logic [CFG_WIDTH-1:0] RST_BACKOFF_LENGTH   = 16'd200;

endpackage

`default_nettype wire

// ----- rtl/core/tsh_pace.sv -----
// ----------------------------------------------------------------------------
// tsh_pace
// Per-axis step pacing: steps and reloads when the down-counter is zero,
// otherwise decrements. Holds the counter when not enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module tsh_pace #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                   en,
  input  wire logic [COUNT_WIDTH-1:0] cnt,
  input  wire logic [COUNT_WIDTH-1:0] interval,
  output logic                        step,
  output logic [COUNT_WIDTH-1:0]      cnt_nxt
);

  always_comb begin
    step    = 1'b0;
    cnt_nxt = cnt;
    if (en) begin
      if (cnt == '0) begin
        step    = 1'b1;
        cnt_nxt = interval;
      end else begin
        cnt_nxt = cnt - COUNT_WIDTH'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/two_axis_stepper_homing_core.sv -----
// ----------------------------------------------------------------------------
// two_axis_stepper_homing_core
// Two-pass homing sequencer for two stepper axes (coarse, backoff, fine,
// fine backoff, done).
//
// Input beats carry a start command or one timer tick with the X/Y min-limit
// switch levels. Every input beat yields exactly one output beat with the
// step pulses, directions, running flag, ready pulse and the phase after it.
// A beat lands in an input register, then one pass of logic updates the
// sequencer state and loads the output register. One beat per cycle is
// sustained while the receiver keeps out_stall low. When the receiver
// stalls, the output beat holds; one more beat is taken into the input
// register, then in_stall rises until the output moves.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
// issue them only while the core is idle.
// Synchronous reset puts the sequencer in idle with counters and directions
// cleared, loads the register defaults and empties both beat registers.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_stepper_homing_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [tsh_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  wire logic [tsh_pkg::CFG_WIDTH-1:0]        cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_op,
  input  wire logic                                 in_x_limit,
  input  wire logic                                 in_y_limit,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_step_x,
  output logic                                      out_step_y,
  output logic                                      out_dir_x,
  output logic                                      out_dir_y,
  output logic                                      out_running,
  output logic                                      out_ready_pulse,
  output logic [2:0]                                out_phase_now
);

  import tsh_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  // configuration
  logic [CFG_WIDTH-1:0] coarse_iv_r, fine_iv_r, backoff_iv_r, backoff_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_iv_r   <= RST_COARSE_INTERVAL;
      fine_iv_r     <= RST_FINE_INTERVAL;
      backoff_iv_r  <= RST_BACKOFF_INTERVAL;
      backoff_len_r <= RST_BACKOFF_LENGTH;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_COARSE_INTERVAL:  coarse_iv_r   <= cfg_wdata;
        REG_FINE_INTERVAL:    fine_iv_r     <= cfg_wdata;
        REG_BACKOFF_INTERVAL: backoff_iv_r  <= cfg_wdata;
        REG_BACKOFF_LENGTH:   backoff_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic in_v_r, op_r, xl_r, yl_r;
  logic move;

  assign move     = in_v_r && (!out_valid || !out_stall);
  assign in_stall = in_v_r && !move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r <= in_op;
      xl_r <= in_x_limit;
      yl_r <= in_y_limit;
    end
  end

  // sequencer state
  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] x_cnt_r, y_cnt_r, bl_r;
  logic [CW-1:0] x_cnt_nxt, y_cnt_nxt, bl_nxt;
  logic          dir_x_r, dir_y_r, dir_x_nxt, dir_y_nxt;
  logic [CW-1:0] iv;
  logic          en_x, en_y, step_x, step_y, ready, running;
  logic          fine;

  tsh_pace #(.COUNT_WIDTH(CW)) u_pace_x (
    .en       (en_x),
    .cnt      (x_cnt_r),
    .interval (iv),
    .step     (step_x),
    .cnt_nxt  (x_cnt_nxt)
  );

  tsh_pace #(.COUNT_WIDTH(CW)) u_pace_y (
    .en       (en_y),
    .cnt      (y_cnt_r),
    .interval (iv),
    .step     (step_y),
    .cnt_nxt  (y_cnt_nxt)
  );

  always_comb begin
    phase_nxt = phase_r;
    dir_x_nxt = dir_x_r;
    dir_y_nxt = dir_y_r;
    bl_nxt    = bl_r;
    iv        = CW'(coarse_iv_r);
    en_x      = 1'b0;
    en_y      = 1'b0;
    ready     = 1'b0;
    fine      = 1'b0;
    if (op_t'(op_r) == OP_START) begin
      phase_nxt = PH_COARSE;
      dir_x_nxt = 1'b0;
      dir_y_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_COARSE, PH_FINE: begin
          fine = (phase_r == PH_FINE);
          iv   = fine ? CW'(fine_iv_r) : CW'(coarse_iv_r);
          if (xl_r && yl_r) begin
            phase_nxt = fine ? PH_FINE_BACKOFF : PH_BACKOFF;
            dir_x_nxt = 1'b1;
            dir_y_nxt = 1'b1;
            bl_nxt    = CW'(backoff_len_r);
            iv        = fine ? CW'(fine_iv_r) : CW'(backoff_iv_r);
            en_x      = 1'b1;
            en_y      = 1'b1;
          end else begin
            en_x = !xl_r;
            en_y = !yl_r;
          end
        end
        PH_BACKOFF, PH_FINE_BACKOFF: begin
          fine = (phase_r == PH_FINE_BACKOFF);
          iv   = fine ? CW'(fine_iv_r) : CW'(backoff_iv_r);
          if (bl_r == '0) begin
            if (fine) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_FINE;
              dir_x_nxt = 1'b0;
              dir_y_nxt = 1'b0;
            end
          end else begin
            bl_nxt = bl_r - CW'(1);
            en_x   = 1'b1;
            en_y   = 1'b1;
          end
        end
        PH_DONE: begin
          ready     = 1'b1;
          phase_nxt = PH_IDLE;
        end
        default: ;
      endcase
    end
    running = phase_nxt inside {PH_COARSE, PH_BACKOFF, PH_FINE, PH_FINE_BACKOFF};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      x_cnt_r <= '0;
      y_cnt_r <= '0;
      bl_r    <= '0;
      dir_x_r <= 1'b0;
      dir_y_r <= 1'b0;
    end else if (move) begin
      phase_r <= phase_nxt;
      x_cnt_r <= x_cnt_nxt;
      y_cnt_r <= y_cnt_nxt;
      bl_r    <= bl_nxt;
      dir_x_r <= dir_x_nxt;
      dir_y_r <= dir_y_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_step_x      <= step_x;
      out_step_y      <= step_y;
      out_dir_x       <= dir_x_nxt;
      out_dir_y       <= dir_y_nxt;
      out_running     <= running;
      out_ready_pulse <= ready;
      out_phase_now   <= phase_nxt;
    end
  end

  // checks
  a_ready_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready_pulse |-> out_phase_now == PH_IDLE)
    else $error("ready pulse without return to idle");

  a_step_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_step_x || out_step_y) |-> out_running)
    else $error("step pulse outside a homing run");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !move |=> $stable(phase_r) && $stable(bl_r))
    else $error("sequencer state changed without a beat");

endmodule

`default_nettype wire
